/* rtl/fbsl_pkg.sv */
// Shared types and constants for the FAT boot sector layout checker.
`timescale 1ns / 1ps

package fbsl_pkg;

	localparam int unsigned SECTOR_MIN      = 512;
	localparam int unsigned SECTOR_MAX      = 4096;
	localparam int unsigned SECTOR_SHIFT    = $clog2(SECTOR_MIN);
	localparam int unsigned CLUSTER_MAX     = 'h80;
	localparam int unsigned DIR_ENTRY_BYTES = 32;
	localparam int unsigned DIR_ENTRY_SHIFT = $clog2(DIR_ENTRY_BYTES);
	localparam int unsigned KIND12_LIMIT    = 4085;
	localparam int unsigned KIND16_LIMIT    = 65525;

	// error_flags bit positions
	localparam int unsigned ERR_SECTOR   = 0;
	localparam int unsigned ERR_CLUSTER  = 1;
	localparam int unsigned ERR_TOTAL    = 2;
	localparam int unsigned ERR_RESERVED = 3;
	localparam int unsigned ERR_FAT_LEN  = 4;
	localparam int unsigned ERR_FAT_CNT  = 5;
	localparam int unsigned ERR_W        = 6;

	localparam logic [1:0] KIND_FAT12 = 2'd0;
	localparam logic [1:0] KIND_FAT16 = 2'd1;
	localparam logic [1:0] KIND_FAT32 = 2'd2;

	typedef struct packed {
		logic [15:0] bytes_per_sector;
		logic [7:0]  sectors_per_cluster;
		logic [15:0] total_sectors_short;
		logic [31:0] total_sectors_long;
		logic [15:0] reserved_sectors;
		logic [15:0] fat_length_short;
		logic [31:0] fat_length_long;
		logic [7:0]  fat_copies;
		logic [15:0] root_entries;
		logic [31:0] root_start_cluster;
	} item_t;

	typedef struct packed {
		logic [ERR_W-1:0] error_flags;
		logic [1:0]       fat_kind;
		logic [31:0]      volume_sectors;
		logic [32:0]      first_data_sector;
		logic [31:0]      data_sectors;
		logic [31:0]      cluster_count;
		logic [12:0]      root_dir_sectors;
		logic [27:0]      fat_byte_offset;
		logic [51:0]      root_byte_offset;
		logic [44:0]      data_byte_offset;
		logic [43:0]      volume_bytes;
	} result_t;

endpackage

/* rtl/fat_boot_sector_layout_check.sv */
// Top level: four-stage FAT boot sector check and layout pipeline.
`timescale 1ns / 1ps

// Takes one boot sector beat per cycle when nothing stalls and returns one result beat per item,
// in accept order, from the stage 4 output register. Stage 1 selects the total and FAT length fields,
// forms the 8x32 FAT size product and the root directory sector count; stage 2 runs the
// range checks and sums the first data sector; stage 3 derives data sectors, clusters and
// the shifted byte terms; stage 4 picks the FAT type and final offsets into the output
// register. Sector and cluster sizes are powers of two once checked, so every scale and
// divide is a shift. A stall on the result side backs up stage by stage and reaches the
// item side only when all four stages hold a beat. With any error flag set, all other
// result fields are zero.
module fat_boot_sector_layout_check
	import fbsl_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	// stage valids and flow control
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4 = !v_s4 || !result_stall;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign item_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= item_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// ---------------- stage 1 ----------------
	logic        sec_bad_d, clus_bad_d, cnt_zero_d;
	logic [31:0] total_d, flen_d;
	logic [39:0] fatsec_d;
	logic [12:0] rds_d;
	logic [1:0]  bsh_d;
	logic [2:0]  csh_d;

	always_comb begin
		logic [3:0]  sh;
		logic [21:0] num;
		logic [21:0] round;
		sec_bad_d = 1'b0;
		bsh_d     = 2'd0;
		case (item.bytes_per_sector)
			16'd512:  bsh_d = 2'd0;
			16'd1024: bsh_d = 2'd1;
			16'd2048: bsh_d = 2'd2;
			16'd4096: bsh_d = 2'd3;
			default:  sec_bad_d = 1'b1;
		endcase

		clus_bad_d = 1'b0;
		csh_d      = 3'd0;
		case (item.sectors_per_cluster)
			8'h01:   csh_d = 3'd0;
			8'h02:   csh_d = 3'd1;
			8'h04:   csh_d = 3'd2;
			8'h08:   csh_d = 3'd3;
			8'h10:   csh_d = 3'd4;
			8'h20:   csh_d = 3'd5;
			8'h40:   csh_d = 3'd6;
			8'h80:   csh_d = 3'd7;
			default: clus_bad_d = 1'b1;
		endcase

		total_d = (item.total_sectors_short != 16'd0) ? 32'(item.total_sectors_short)
			: item.total_sectors_long;
		flen_d = (item.fat_length_short != 16'd0) ? 32'(item.fat_length_short)
			: item.fat_length_long;
		fatsec_d   = 40'(item.fat_copies) * 40'(flen_d);
		cnt_zero_d = (item.fat_copies == 8'd0);

		// ceil(entries * 32 / sector size)
		sh    = 4'(SECTOR_SHIFT) + 4'(bsh_d);
		round = (22'd1 << sh) - 22'd1;
		num   = (22'(item.root_entries) << DIR_ENTRY_SHIFT) + round;
		rds_d = 13'(num >> sh);
	end

	logic [2:0]  err_s1;
	logic [31:0] total_s1, flen_s1, rc_s1;
	logic [39:0] fatsec_s1;
	logic [15:0] rsv_s1;
	logic [12:0] rds_s1;
	logic [1:0]  bsh_s1;
	logic [2:0]  csh_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && item_valid) begin
			err_s1    <= {cnt_zero_d, clus_bad_d, sec_bad_d};
			total_s1  <= total_d;
			flen_s1   <= flen_d;
			fatsec_s1 <= fatsec_d;
			rsv_s1    <= item.reserved_sectors;
			rds_s1    <= rds_d;
			rc_s1     <= item.root_start_cluster;
			bsh_s1    <= bsh_d;
			csh_s1    <= csh_d;
		end
	end

	// ---------------- stage 2 ----------------
	logic [ERR_W-1:0] err_d2;
	logic [32:0]      fds_d2;

	always_comb begin
		logic tot_bad, len_bad;
		tot_bad = (total_s1 == 32'd0);
		len_bad = (flen_s1 == 32'd0) || (!tot_bad && flen_s1 > total_s1);
		err_d2 = '0;
		err_d2[ERR_SECTOR]   = err_s1[0];
		err_d2[ERR_CLUSTER]  = err_s1[1];
		err_d2[ERR_TOTAL]    = tot_bad;
		err_d2[ERR_RESERVED] = !tot_bad && (32'(rsv_s1) > total_s1);
		err_d2[ERR_FAT_LEN]  = len_bad;
		err_d2[ERR_FAT_CNT]  = err_s1[2]
			|| (!tot_bad && !len_bad && fatsec_s1 > 40'(total_s1));
		// FAT size fits 32 bits whenever the checks pass
		fds_d2 = 33'(rsv_s1) + 33'(fatsec_s1[31:0]) + 33'(rds_s1);
	end

	logic [ERR_W-1:0] err_s2;
	logic [31:0]      total_s2, fatsec_s2, rc_s2;
	logic [32:0]      fds_s2;
	logic [15:0]      rsv_s2;
	logic [12:0]      rds_s2;
	logic [1:0]       bsh_s2;
	logic [2:0]       csh_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			err_s2    <= err_d2;
			total_s2  <= total_s1;
			fatsec_s2 <= fatsec_s1[31:0];
			fds_s2    <= fds_d2;
			rsv_s2    <= rsv_s1;
			rds_s2    <= rds_s1;
			rc_s2     <= rc_s1;
			bsh_s2    <= bsh_s1;
			csh_s2    <= csh_s1;
		end
	end

	// ---------------- stage 3 ----------------
	logic [31:0] ds_d3, cc_d3;
	logic [27:0] fat_off_d3;
	logic [44:0] fat_end_d3;
	logic [24:0] rds_bytes_d3;
	logic [38:0] rct_d3;
	logic [43:0] vbytes_d3;

	always_comb begin
		logic [3:0]  sh;
		logic [32:0] fat_sum;
		logic [31:0] rcm;
		sh      = 4'(SECTOR_SHIFT) + 4'(bsh_s2);
		ds_d3   = (33'(total_s2) > fds_s2) ? 32'(33'(total_s2) - fds_s2) : 32'd0;
		cc_d3   = ds_d3 >> csh_s2;
		fat_sum = 33'(rsv_s2) + 33'(fatsec_s2);
		fat_off_d3   = 28'(rsv_s2) << sh;
		fat_end_d3   = 45'(fat_sum) << sh;
		rds_bytes_d3 = 25'(rds_s2) << sh;
		vbytes_d3    = 44'(total_s2) << sh;
		// root cluster below 2 counts as 2
		rcm    = (rc_s2 < 32'd2) ? 32'd0 : (rc_s2 - 32'd2);
		rct_d3 = 39'(rcm) << csh_s2;
	end

	logic [ERR_W-1:0] err_s3;
	logic [31:0]      total_s3, ds_s3, cc_s3;
	logic [32:0]      fds_s3;
	logic [12:0]      rds_s3;
	logic [27:0]      fat_off_s3;
	logic [44:0]      fat_end_s3;
	logic [24:0]      rds_bytes_s3;
	logic [38:0]      rct_s3;
	logic [43:0]      vbytes_s3;
	logic [1:0]       bsh_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			err_s3       <= err_s2;
			total_s3     <= total_s2;
			ds_s3        <= ds_d3;
			cc_s3        <= cc_d3;
			fds_s3       <= fds_s2;
			rds_s3       <= rds_s2;
			fat_off_s3   <= fat_off_d3;
			fat_end_s3   <= fat_end_d3;
			rds_bytes_s3 <= rds_bytes_d3;
			rct_s3       <= rct_d3;
			vbytes_s3    <= vbytes_d3;
			bsh_s3       <= bsh_s2;
		end
	end

	// ---------------- stage 4: output register ----------------
	result_t res_d4;

	always_comb begin
		logic [3:0]  sh;
		logic [1:0]  kind;
		logic [39:0] root_sec;
		logic [51:0] root32;
		logic [44:0] data16;
		sh = 4'(SECTOR_SHIFT) + 4'(bsh_s3);
		if (cc_s3 < 32'(KIND12_LIMIT))
			kind = KIND_FAT12;
		else if (cc_s3 < 32'(KIND16_LIMIT))
			kind = KIND_FAT16;
		else
			kind = KIND_FAT32;
		root_sec = 40'(rct_s3) + 40'(fds_s3);
		root32   = 52'(root_sec) << sh;
		data16   = fat_end_s3 + 45'(rds_bytes_s3);

		res_d4 = '0;
		res_d4.error_flags = err_s3;
		if (err_s3 == '0) begin
			res_d4.fat_kind          = kind;
			res_d4.volume_sectors    = total_s3;
			res_d4.first_data_sector = fds_s3;
			res_d4.data_sectors      = ds_s3;
			res_d4.cluster_count     = cc_s3;
			res_d4.root_dir_sectors  = rds_s3;
			res_d4.fat_byte_offset   = fat_off_s3;
			res_d4.volume_bytes      = vbytes_s3;
			if (kind == KIND_FAT32) begin
				res_d4.root_byte_offset = root32;
				res_d4.data_byte_offset = fat_end_s3;
			end else begin
				res_d4.root_byte_offset = 52'(fat_end_s3);
				res_d4.data_byte_offset = data16;
			end
		end
	end

	result_t res_s4;

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) res_s4 <= res_d4;
	end

	assign result_valid = v_s4;
	assign result       = res_s4;

`ifndef SYNTHESIS
	// an errored beat carries no layout
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.error_flags != '0) |->
		(result.fat_kind == '0 && result.volume_sectors == '0
		&& result.first_data_sector == '0 && result.root_byte_offset == '0
		&& result.data_byte_offset == '0 && result.volume_bytes == '0))
		else $error("layout fields not cleared on error");

	// reserved check is suppressed when the total itself is bad
	a_err_order: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.error_flags[ERR_TOTAL]) |->
		!result.error_flags[ERR_RESERVED])
		else $error("reserved error raised with total error");

	// item side stalls only with every stage full
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && result_stall))
		else $error("input stalled with a bubble in the pipe");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.fat_kind == KIND_FAT12 || result.fat_kind == KIND_FAT16
		|| result.fat_kind == KIND_FAT32))
		else $error("bad FAT type code");
`endif

endmodule

/* test/fat_boot_sector_layout_check_test.sv */
// Testbench for the FAT boot sector checker: directed and random volumes, scoreboard compare.
`timescale 1ns / 1ps

module fat_boot_sector_layout_check_test;
	import fbsl_pkg::*;

	localparam int unsigned RANDOM_VOLUMES = 1400;
	localparam int unsigned QUIET_FROM     = 1250;
	localparam int unsigned CYCLE_LIMIT    = 400000;
	localparam int unsigned HOLD_AFTER     = 300;
	localparam int unsigned HOLD_CYCLES    = 90;

	// expected layouts in accept order, checked against each result beat
	class volume_layout_scoreboard;
		result_t     expected_layouts[$];
		int unsigned mismatches;
		int unsigned kind_seen[3];
		int unsigned rejected;

		function automatic result_t layout_of(item_t it);
			logic [63:0] bps, spc, total, flen, fatsec, rsv, copies, rent;
			logic [63:0] rds, fds, ds, cc, fat_off, root_off, data_off, rc;
			logic [ERR_W-1:0] err;
			logic [1:0] kind;
			result_t r;
			bps = it.bytes_per_sector;
			spc = it.sectors_per_cluster;
			rsv = it.reserved_sectors;
			copies = it.fat_copies;
			rent = it.root_entries;
			err = '0;
			if (!(bps >= SECTOR_MIN && bps <= SECTOR_MAX && (bps & (bps - 1)) == 0))
				err[ERR_SECTOR] = 1'b1;
			if (!(spc != 0 && spc <= CLUSTER_MAX && (spc & (spc - 1)) == 0))
				err[ERR_CLUSTER] = 1'b1;
			total = (it.total_sectors_short != 0) ? 64'(it.total_sectors_short)
				: 64'(it.total_sectors_long);
			if (total == 0)
				err[ERR_TOTAL] = 1'b1;
			if (!err[ERR_TOTAL] && rsv > total)
				err[ERR_RESERVED] = 1'b1;
			flen = (it.fat_length_short != 0) ? 64'(it.fat_length_short)
				: 64'(it.fat_length_long);
			if (flen == 0 || (!err[ERR_TOTAL] && flen > total))
				err[ERR_FAT_LEN] = 1'b1;
			// full-width product, never wraps
			fatsec = copies * flen;
			if (copies == 0 || (!err[ERR_TOTAL] && !err[ERR_FAT_LEN] && fatsec > total))
				err[ERR_FAT_CNT] = 1'b1;
			r = '0;
			r.error_flags = err;
			if (err != 0)
				return r;
			rds = (rent * DIR_ENTRY_BYTES + bps - 1) / bps;
			fds = rsv + fatsec + rds;
			ds = (total > fds) ? total - fds : 64'd0;
			cc = ds / spc;
			kind = (cc < KIND12_LIMIT) ? KIND_FAT12 : (cc < KIND16_LIMIT) ? KIND_FAT16 : KIND_FAT32;
			fat_off = rsv * bps;
			if (kind == KIND_FAT32) begin
				rc = (it.root_start_cluster < 2) ? 64'd2 : 64'(it.root_start_cluster);
				root_off = ((rc - 2) * spc + fds) * bps;
				data_off = fat_off + fatsec * bps;
			end else begin
				root_off = fat_off + fatsec * bps;
				data_off = root_off + rds * bps;
			end
			r.fat_kind = kind;
			r.volume_sectors = total[31:0];
			r.first_data_sector = fds[32:0];
			r.data_sectors = ds[31:0];
			r.cluster_count = cc[31:0];
			r.root_dir_sectors = rds[12:0];
			r.fat_byte_offset = fat_off[27:0];
			r.root_byte_offset = root_off[51:0];
			r.data_byte_offset = data_off[44:0];
			r.volume_bytes = 44'(total * bps);
			return r;
		endfunction

		function void note_item(item_t it);
			result_t want;
			want = layout_of(it);
			expected_layouts.insert(expected_layouts.size(), want);
			if (want.error_flags != 0)
				rejected++;
			else
				kind_seen[want.fat_kind]++;
		endfunction

		function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_layouts.size() == 0) begin
				$display("%0t: result beat with nothing expected: expected none, actual %h",
					$time, got);
				mismatches++;
				return;
			end
			want = expected_layouts.pop_front();
			cmp_field("error_flags", want.error_flags, got.error_flags);
			cmp_field("fat_kind", want.fat_kind, got.fat_kind);
			cmp_field("volume_sectors", want.volume_sectors, got.volume_sectors);
			cmp_field("first_data_sector", want.first_data_sector, got.first_data_sector);
			cmp_field("data_sectors", want.data_sectors, got.data_sectors);
			cmp_field("cluster_count", want.cluster_count, got.cluster_count);
			cmp_field("root_dir_sectors", want.root_dir_sectors, got.root_dir_sectors);
			cmp_field("fat_byte_offset", want.fat_byte_offset, got.fat_byte_offset);
			cmp_field("root_byte_offset", want.root_byte_offset, got.root_byte_offset);
			cmp_field("data_byte_offset", want.data_byte_offset, got.data_byte_offset);
			cmp_field("volume_bytes", want.volume_bytes, got.volume_bytes);
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	volume_layout_scoreboard sb;
	int unsigned accepted_items;
	int unsigned cycles;
	bit          quiet_tail;
	bit          held_off;

	fat_boot_sector_layout_check u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				sb.expected_layouts.size());
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
	end

	// result side: random stall bursts, one long hold-off to back the pipe up
	initial begin
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held_off && accepted_items >= HOLD_AFTER) begin
				held_off = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_stall <= 1'b0;
			end else if (!quiet_tail && $urandom_range(99, 0) < 15) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(11, 1)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	function automatic item_t boot_sector(logic [15:0] bps, logic [7:0] spc, logic [15:0] ts16,
			logic [31:0] ts32, logic [15:0] rsv, logic [15:0] fl16, logic [31:0] fl32,
			logic [7:0] copies, logic [15:0] rent, logic [31:0] rclus);
		item_t v;
		v.bytes_per_sector = bps;
		v.sectors_per_cluster = spc;
		v.total_sectors_short = ts16;
		v.total_sectors_long = ts32;
		v.reserved_sectors = rsv;
		v.fat_length_short = fl16;
		v.fat_length_long = fl32;
		v.fat_copies = copies;
		v.root_entries = rent;
		v.root_start_cluster = rclus;
		return v;
	endfunction

	// mostly well-formed volumes with random geometry; some noise, some with one bad field
	function automatic item_t random_volume();
		item_t v;
		int unsigned mode;
		logic [31:0] total, flmax, flen;
		mode = $urandom_range(99, 0);
		if (mode < 12) begin
			v.bytes_per_sector = 16'($urandom);
			v.sectors_per_cluster = 8'($urandom);
			v.total_sectors_short = 16'($urandom);
			v.total_sectors_long = $urandom;
			v.reserved_sectors = 16'($urandom);
			v.fat_length_short = 16'($urandom);
			v.fat_length_long = $urandom;
			v.fat_copies = 8'($urandom);
			v.root_entries = 16'($urandom);
			v.root_start_cluster = $urandom;
			return v;
		end
		v.bytes_per_sector = 16'(SECTOR_MIN << $urandom_range(3, 0));
		v.sectors_per_cluster = 8'(1 << $urandom_range(7, 0));
		case ($urandom_range(2, 0))
			0: begin
				total = $urandom_range(65535, 1);
				v.total_sectors_short = total[15:0];
				v.total_sectors_long = $urandom;
			end
			1: begin
				total = $urandom_range(2000000, 65536);
				v.total_sectors_short = '0;
				v.total_sectors_long = total;
			end
			default: begin
				total = $urandom_range(32'hFFFF_FFFF, 2000000);
				v.total_sectors_short = '0;
				v.total_sectors_long = total;
			end
		endcase
		v.reserved_sectors = ($urandom_range(3, 0) == 0) ? 16'($urandom_range(65535, 0))
			: 16'($urandom_range(32, 1));
		if (v.reserved_sectors > total)
			v.reserved_sectors = total[15:0];
		v.fat_copies = ($urandom_range(7, 0) == 0) ? 8'($urandom_range(255, 1))
			: 8'($urandom_range(2, 1));
		flmax = total / (v.fat_copies * $urandom_range(64, 1));
		if (flmax == 0)
			flmax = 1;
		flen = $urandom_range(flmax, 1);
		if (flen < 65536 && $urandom_range(1, 0) == 1) begin
			v.fat_length_short = flen[15:0];
			v.fat_length_long = $urandom;
		end else begin
			v.fat_length_short = '0;
			v.fat_length_long = flen;
		end
		case ($urandom_range(2, 0))
			0: v.root_entries = '0;
			1: v.root_entries = 16'd512;
			default: v.root_entries = 16'($urandom_range(65535, 0));
		endcase
		v.root_start_cluster = ($urandom_range(1, 0) == 1) ? $urandom : $urandom_range(5, 0);
		if (mode < 25) begin
			case ($urandom_range(5, 0))
				0: v.bytes_per_sector = 16'($urandom);
				1: v.sectors_per_cluster = 8'($urandom);
				2: begin
					v.total_sectors_short = '0;
					v.total_sectors_long = '0;
				end
				3: v.reserved_sectors = 16'($urandom);
				4: begin
					v.fat_length_short = '0;
					v.fat_length_long = ($urandom_range(1, 0) == 1) ? '0 : $urandom;
				end
				default: v.fat_copies = 8'($urandom);
			endcase
		end
		return v;
	endfunction

	task automatic send_volume(input item_t it);
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.note_item(it);
		accepted_items++;
		if (!quiet_tail && $urandom_range(99, 0) < 20) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(11, 1)) @(posedge clk);
		end
	endtask

	initial begin
		int unsigned settle;
		sb = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cycles = 0;
		accepted_items = 0;
		quiet_tail = 1'b0;
		held_off = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain FAT12, FAT16 and FAT32 volumes
		send_volume(boot_sector(512, 1, 2880, 0, 1, 9, 0, 2, 224, 0));
		send_volume(boot_sector(512, 4, 0, 200000, 4, 200, 0, 2, 512, 0));
		send_volume(boot_sector(512, 8, 0, 4000000, 32, 0, 4000, 2, 0, 2));
		// root cluster below 2 counts as 2
		send_volume(boot_sector(512, 8, 0, 4000000, 32, 0, 4000, 2, 0, 0));
		// widest FAT32 volume
		send_volume(boot_sector(4096, 128, 0, 32'hFFFF_FFFF, 16'hFFFF, 0, 32'h00FF_FFFF, 255,
			16'hFFFF, 32'hFFFF_FFFF));
		// total zero masks the reserved, length-vs-total and count checks
		send_volume(boot_sector(1024, 2, 0, 0, 16'hFFFF, 1, 0, 1, 0, 0));
		// bad sector and cluster sizes
		send_volume(boot_sector(0, 1, 1000, 0, 1, 1, 0, 1, 0, 0));
		send_volume(boot_sector(511, 0, 1000, 0, 1, 1, 0, 1, 0, 0));
		send_volume(boot_sector(513, 3, 1000, 0, 1, 1, 0, 1, 0, 0));
		send_volume(boot_sector(1536, 255, 1000, 0, 1, 1, 0, 1, 0, 0));
		send_volume(boot_sector(8192, 64, 1000, 0, 1, 1, 0, 1, 0, 0));
		send_volume(boot_sector(16'hFFFF, 128, 1000, 0, 1, 1, 0, 1, 0, 0));
		// reserved past total; reserved equal to total saturates data sectors
		send_volume(boot_sector(512, 1, 10, 0, 11, 1, 0, 1, 0, 0));
		send_volume(boot_sector(512, 1, 10, 0, 10, 1, 0, 1, 0, 0));
		// FAT length zero, FAT length past total
		send_volume(boot_sector(512, 1, 1000, 0, 1, 0, 0, 2, 0, 0));
		send_volume(boot_sector(512, 1, 1000, 0, 1, 0, 1001, 2, 0, 0));
		// no FAT copies; copies times length past total without wrap
		send_volume(boot_sector(512, 1, 1000, 0, 1, 10, 0, 0, 0, 0));
		send_volume(boot_sector(512, 1, 0, 32'hFFFF_FFFF, 1, 0, 32'hFFFF_FFFF, 255, 0, 0));
		// short fields win over long ones
		send_volume(boot_sector(2048, 16, 50000, 32'hDEAD_BEEF, 8, 100, 32'h1234_5678, 2, 512, 5));
		// root dir sectors round up
		send_volume(boot_sector(512, 1, 3000, 0, 1, 5, 0, 2, 17, 0));
		// cluster count on both sides of each type limit
		send_volume(boot_sector(512, 1, 4086, 0, 1, 1, 0, 1, 0, 0));
		send_volume(boot_sector(512, 1, 4087, 0, 1, 1, 0, 1, 0, 0));
		send_volume(boot_sector(512, 1, 65526, 0, 1, 1, 0, 1, 0, 0));
		send_volume(boot_sector(512, 1, 65527, 0, 1, 1, 0, 1, 0, 0));
		send_volume('1);

		for (int unsigned i = 0; i < RANDOM_VOLUMES; i++) begin
			if (i == QUIET_FROM)
				quiet_tail = 1'b1;
			send_volume(random_volume());
		end
		item_valid <= 1'b0;

		while (sb.expected_layouts.size() != 0)
			@(posedge clk);
		settle = 20;
		repeat (settle) @(posedge clk);

		$display("%0d volumes checked: %0d FAT12, %0d FAT16, %0d FAT32, %0d rejected",
			accepted_items, sb.kind_seen[KIND_FAT12], sb.kind_seen[KIND_FAT16],
			sb.kind_seen[KIND_FAT32], sb.rejected);
		$display("stalls on both sides with one long output hold-off; %0d mismatches",
			sb.mismatches);
		if (sb.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
